// ===== rtl/setq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setq_pkg
// Shared types and constants for the sorted expiry timer queue.
// ----------------------------------------------------------------------------
package setq_pkg;

  localparam int DEPTH     = 64;
  localparam int TIME_BITS = 32;
  localparam int HANDLES   = 64;
  localparam int HANDLE_W  = 6;
  localparam int IN_TIME_W = 32;
  localparam int TW        = (TIME_BITS < IN_TIME_W) ? TIME_BITS : IN_TIME_W;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_ADJUST = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_TICK   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ACTIVE     = 2'd1,
    ST_NOT_ACTIVE = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FWD,
    S_BWD
  } state_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [TW-1:0]       expiry;
  } entry_t;

endpackage

// ===== rtl/sorted_expiry_timer_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_expiry_timer_queue
// Sorted timer list: slots held in ascending expiry order in one RAM, walked
// one slot per cycle by a small sequencer.
//
//   channel   ports                                         handshake
//   command   func handle expire_time now_time              start, busy
//   result    status fired fired_handle last                valid
//
// Add walks the list backwards, delete walks it forwards, adjust does both
// (forwards, then backwards) and tick walks forwards. All walks share the
// single RAM read/write port pair.
// Results are registered: each comes in the cycle after the step that makes
// it, a burst of fired timers on consecutive cycles. Reset empties the list
// at once.
// The receiver cannot stall results.
// ----------------------------------------------------------------------------
module sorted_expiry_timer_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  setq_pkg::func_t       func,
  input  logic [5:0]            handle,
  input  logic [31:0]           expire_time,
  input  logic [31:0]           now_time,
  output logic                  valid,
  output setq_pkg::status_t     status,
  output logic                  fired,
  output logic [5:0]            fired_handle,
  output logic                  last
);
  import setq_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data;

  state_t state, state_next;
  logic [CNT_W-1:0] rc, rc_next;
  logic [CNT_W-1:0] used, used_next;
  logic [CNT_W-1:0] gap, gap_next;
  logic             expiring, expiring_next;
  logic             pending, pending_next;
  logic [HANDLE_W-1:0] pend_h, pend_h_next;
  logic             v1;
  logic [IDX_W-1:0] a1;
  logic [HANDLES-1:0] active;

  func_t               op;
  logic [HANDLE_W-1:0] op_h;
  logic [TW-1:0]       op_exp;
  logic [TW-1:0]       op_now;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             act_we;
  logic [HANDLE_W-1:0] act_idx;
  logic             act_val;

  logic             valid_next;
  status_t          status_next;
  logic             fired_next;
  logic [HANDLE_W-1:0] fired_handle_next;
  logic             last_next;

  logic [CNT_W-1:0] rc_dec;
  logic [CNT_W-1:0] down_addr;
  logic [IDX_W-1:0] up_addr;
  logic             accept;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign rc_dec    = rc - 1'b1;
  assign down_addr = CNT_W'(a1) - gap;
  assign up_addr   = a1 + 1'b1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      used   <= '0;
      active <= '0;
      valid  <= 1'b0;
      v1     <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      valid <= valid_next;
      v1    <= rd_en;
      if (act_we) begin
        active[act_idx] <= act_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    rc           <= rc_next;
    gap          <= gap_next;
    expiring     <= expiring_next;
    pending      <= pending_next;
    pend_h       <= pend_h_next;
    a1           <= rd_addr;
    status       <= status_next;
    fired        <= fired_next;
    fired_handle <= fired_handle_next;
    last         <= last_next;
    if (accept) begin
      op     <= func;
      op_h   <= handle;
      op_exp <= expire_time[TW-1:0];
      op_now <= now_time[TW-1:0];
    end
  end

  always_comb begin
    state_next        = state;
    rc_next           = rc;
    used_next         = used;
    gap_next          = gap;
    expiring_next     = expiring;
    pending_next      = pending;
    pend_h_next       = pend_h;
    rd_en             = 1'b0;
    rd_addr           = rc[IDX_W-1:0];
    wr_en             = 1'b0;
    wr_addr           = down_addr[IDX_W-1:0];
    wr_data           = rd_data;
    act_we            = 1'b0;
    act_idx           = handle;
    act_val           = 1'b0;
    valid_next        = 1'b0;
    status_next       = ST_OK;
    fired_next        = 1'b0;
    fired_handle_next = '0;
    last_next         = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          rc_next       = '0;
          gap_next      = '0;
          expiring_next = 1'b1;
          pending_next  = 1'b0;
          unique case (func)
            FUNC_ADD: begin
              if (active[handle]) begin
                valid_next  = 1'b1;
                status_next = ST_ACTIVE;
              end else if (used == CNT_W'(DEPTH)) begin
                valid_next  = 1'b1;
                status_next = ST_FULL;
              end else begin
                act_we     = 1'b1;
                act_val    = 1'b1;
                rc_next    = used;
                state_next = S_BWD;
              end
            end
            FUNC_ADJUST, FUNC_DELETE: begin
              if (!active[handle]) begin
                valid_next  = 1'b1;
                status_next = ST_NOT_ACTIVE;
              end else begin
                act_we     = (func == FUNC_DELETE);
                state_next = S_FWD;
              end
            end
            FUNC_TICK: begin
              state_next = S_FWD;
            end
            default: ;
          endcase
        end
      end

      S_FWD: begin
        if (rc != used) begin
          rd_en   = 1'b1;
          rc_next = rc + 1'b1;
        end
        if (v1) begin
          if (op == FUNC_TICK) begin
            if (expiring && rd_data.expiry <= op_now) begin
              gap_next = gap + 1'b1;
              act_we   = 1'b1;
              act_idx  = rd_data.handle;
              if (pending) begin
                valid_next        = 1'b1;
                fired_next        = 1'b1;
                fired_handle_next = pend_h;
                last_next         = 1'b0;
              end
              pending_next = 1'b1;
              pend_h_next  = rd_data.handle;
            end else begin
              expiring_next = 1'b0;
              if (pending) begin
                valid_next        = 1'b1;
                fired_next        = 1'b1;
                fired_handle_next = pend_h;
                pending_next      = 1'b0;
              end
              wr_en = (gap != '0);
            end
          end else if (gap == '0 && rd_data.handle == op_h) begin
            gap_next = CNT_W'(1);
          end else begin
            wr_en = (gap != '0);
          end
        end else if (rc == used) begin
          // walk finished: close the gap left behind
          used_next = used - gap;
          if (op == FUNC_TICK) begin
            state_next = S_IDLE;
            if (pending) begin
              valid_next        = 1'b1;
              fired_next        = 1'b1;
              fired_handle_next = pend_h;
            end else if (gap == '0) begin
              valid_next = 1'b1;
            end
          end else if (op == FUNC_DELETE) begin
            state_next = S_IDLE;
            valid_next = 1'b1;
          end else begin
            rc_next    = used - gap;
            state_next = S_BWD;
          end
        end
      end

      S_BWD: begin
        if (rc != '0) begin
          rd_en   = 1'b1;
          rd_addr = rc_dec[IDX_W-1:0];
          rc_next = rc_dec;
        end
        if (v1) begin
          wr_en   = 1'b1;
          wr_addr = up_addr;
          if (rd_data.expiry <= op_exp) begin
            wr_data    = '{handle: op_h, expiry: op_exp};
            used_next  = used + 1'b1;
            valid_next = 1'b1;
            state_next = S_IDLE;
          end
        end else if (rc == '0) begin
          wr_en      = 1'b1;
          wr_addr    = '0;
          wr_data    = '{handle: op_h, expiry: op_exp};
          used_next  = used + 1'b1;
          valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(DEPTH))
    else $error("slot count beyond depth");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    valid && !last |=> valid)
    else $error("fired burst broken");

  a_not_fired_last: assert property (@(posedge clk) disable iff (rst)
    valid && !fired |-> last && fired_handle == '0)
    else $error("plain result not final");

  a_busy_quiet: assert property (@(posedge clk) disable iff (rst)
    valid && !fired |-> !$past(valid && !last))
    else $error("plain result inside a burst");

endmodule

// ===== bench/sorted_expiry_timer_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_expiry_timer_queue_tb
// Self-checking bench for the sorted expiry timer queue. A directed opening
// covers the empty list, equal-expiry ordering, adjust in both directions,
// status codes and time extremes. Random traffic follows: clustered
// add/adjust/delete/tick runs, two full-list fills flushed by a tick, and
// noise. A shadow timer list predicts every beat. The monitor checks each
// result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_expiry_timer_queue_tb;
  import setq_pkg::*;

  typedef struct {
    func_t       op;
    logic [5:0]  h;
    logic [31:0] exp_t;
    logic [31:0] now_t;
    int unsigned gap;
    bit          drain;
  } timer_cmd_t;

  typedef struct {
    status_t    st;
    bit         fired;
    logic [5:0] fh;
    bit         last;
  } timer_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  func_t       func = FUNC_ADD;
  logic [5:0]  handle = '0;
  logic [31:0] expire_time = '0;
  logic [31:0] now_time = '0;
  logic        valid;
  status_t     status;
  logic        fired;
  logic [5:0]  fired_handle;
  logic        last;

  timer_cmd_t    cmd_queue[$];
  timer_report_t timer_reports[$];
  entry_t        timer_list[$];
  bit            live[HANDLES];

  timer_cmd_t  cur_cmd;
  bit          have_cur = 1'b0;
  int unsigned idle_left = 0;
  bit          no_gaps = 1'b0;
  int          fails = 0;
  int          cmds_sent = 0;
  int          beats_checked = 0;
  int          timers_fired = 0;
  int          tick_burst = 0;
  int          max_burst = 0;

  sorted_expiry_timer_queue u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .handle       (handle),
    .expire_time  (expire_time),
    .now_time     (now_time),
    .valid        (valid),
    .status       (status),
    .fired        (fired),
    .fired_handle (fired_handle),
    .last         (last)
  );

  always #1 clk = ~clk;

  function automatic void push_report(status_t st, bit f, logic [5:0] fh, bit l);
    timer_report_t r;
    r.st    = st;
    r.fired = f;
    r.fh    = fh;
    r.last  = l;
    timer_reports.push_back(r);
  endfunction

  function automatic void insert_timer(logic [5:0] h, logic [TW-1:0] e);
    entry_t ent;
    int     pos;
    pos = 0;
    while (pos < timer_list.size() && timer_list[pos].expiry <= e) pos++;
    ent.handle = h;
    ent.expiry = e;
    timer_list.insert(pos, ent);
  endfunction

  // shadow of the timer list; pushes the beats one command produces
  function automatic void apply_timer_cmd(timer_cmd_t c);
    logic [TW-1:0] e;
    logic [TW-1:0] t;
    int            n;
    e = c.exp_t[TW-1:0];
    t = c.now_t[TW-1:0];
    case (c.op)
      FUNC_ADD: begin
        if (live[c.h]) begin
          push_report(ST_ACTIVE, 1'b0, '0, 1'b1);
        end else if (timer_list.size() >= DEPTH) begin
          push_report(ST_FULL, 1'b0, '0, 1'b1);
        end else begin
          insert_timer(c.h, e);
          live[c.h] = 1'b1;
          push_report(ST_OK, 1'b0, '0, 1'b1);
        end
      end
      FUNC_ADJUST, FUNC_DELETE: begin
        if (!live[c.h]) begin
          push_report(ST_NOT_ACTIVE, 1'b0, '0, 1'b1);
        end else begin
          for (int i = 0; i < timer_list.size(); i++) begin
            if (timer_list[i].handle == c.h) begin
              timer_list.delete(i);
              break;
            end
          end
          if (c.op == FUNC_ADJUST) insert_timer(c.h, e);
          else live[c.h] = 1'b0;
          push_report(ST_OK, 1'b0, '0, 1'b1);
        end
      end
      default: begin
        n = 0;
        while (n < timer_list.size() && timer_list[n].expiry <= t) n++;
        if (n == 0) begin
          push_report(ST_OK, 1'b0, '0, 1'b1);
        end else begin
          for (int j = 0; j < n; j++) begin
            live[timer_list[0].handle] = 1'b0;
            push_report(ST_OK, 1'b1, timer_list[0].handle, j == n - 1);
            void'(timer_list.pop_front());
          end
        end
      end
    endcase
  endfunction

  function automatic void queue_cmd(func_t op, int h, logic [31:0] e, logic [31:0] t,
                                    bit drain);
    timer_cmd_t c;
    c.op    = op;
    c.h     = h[5:0];
    c.exp_t = e;
    c.now_t = t;
    c.gap   = no_gaps ? 0 : $urandom_range(0, 10);
    c.drain = drain;
    cmd_queue.push_back(c);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_timer_cmd(cur_cmd);
        cmds_sent++;
        have_cur = 1'b0;
      end
      if (!(start && busy)) begin
        if (!have_cur && cmd_queue.size() != 0) begin
          cur_cmd   = cmd_queue.pop_front();
          have_cur  = 1'b1;
          idle_left = cur_cmd.gap;
        end
        if (have_cur && idle_left == 0 &&
            !(cur_cmd.drain && (timer_reports.size() != 0 || valid))) begin
          start       <= 1'b1;
          func        <= cur_cmd.op;
          handle      <= cur_cmd.h;
          expire_time <= cur_cmd.exp_t;
          now_time    <= cur_cmd.now_t;
        end else begin
          start <= 1'b0;
          if (have_cur && idle_left != 0) idle_left--;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    timer_report_t want;
    if (!rst && valid) begin
      if (timer_reports.size() == 0) begin
        $error("unexpected result beat: status %0d fired %0b handle %0d last %0b",
               status, fired, fired_handle, last);
        fails++;
      end else begin
        want = timer_reports.pop_front();
        beats_checked++;
        if (status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status);
          fails++;
        end
        if (fired !== want.fired) begin
          $error("fired: expected %0b, got %0b", want.fired, fired);
          fails++;
        end
        if (fired_handle !== want.fh) begin
          $error("fired_handle: expected %0d, got %0d", want.fh, fired_handle);
          fails++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          fails++;
        end
        if (want.fired) begin
          timers_fired++;
          tick_burst++;
          if (tick_burst > max_burst) max_burst = tick_burst;
        end
        if (want.last) tick_burst = 0;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int          order[64];
    int          tmp;
    int          k;
    int          target;
    int          seq_len;
    int          pool_lo;
    int          r;
    logic [31:0] base;

    // directed opening
    queue_cmd(FUNC_TICK, 0, 32'd0, 32'd0, 1'b0);
    queue_cmd(FUNC_DELETE, 5, 32'd0, 32'd0, 1'b0);
    queue_cmd(FUNC_ADJUST, 7, 32'h1234, 32'd0, 1'b0);
    queue_cmd(FUNC_ADD, 0, 32'd0, 32'd0, 1'b0);
    queue_cmd(FUNC_ADD, 63, 32'hFFFF_FFFF, 32'd0, 1'b0);
    queue_cmd(FUNC_ADD, 10, 32'd100, 32'd0, 1'b0);
    queue_cmd(FUNC_ADD, 11, 32'd100, 32'd0, 1'b0);
    queue_cmd(FUNC_ADD, 10, 32'd5, 32'd0, 1'b0);
    queue_cmd(FUNC_ADJUST, 10, 32'd100, 32'd0, 1'b0);
    queue_cmd(FUNC_ADJUST, 63, 32'd50, 32'd0, 1'b0);
    queue_cmd(FUNC_ADJUST, 11, 32'd200, 32'd0, 1'b0);
    queue_cmd(FUNC_DELETE, 0, 32'd0, 32'd0, 1'b0);
    queue_cmd(FUNC_DELETE, 0, 32'd0, 32'd0, 1'b0);
    queue_cmd(FUNC_TICK, 0, 32'd0, 32'd49, 1'b0);
    queue_cmd(FUNC_TICK, 0, 32'd0, 32'd100, 1'b0);
    queue_cmd(FUNC_ADD, 42, 32'hFFFF_FFFF, 32'd0, 1'b0);
    queue_cmd(FUNC_ADD, 21, 32'hAAAA_AAAA, 32'd0, 1'b0);
    queue_cmd(FUNC_TICK, 0, 32'd0, 32'hFFFF_FFFE, 1'b1);
    queue_cmd(FUNC_TICK, 0, 32'd0, 32'hFFFF_FFFF, 1'b0);

    target = 320;
    k = 0;
    while (cmd_queue.size() < target) begin
      no_gaps = ($urandom_range(0, 2) == 0);
      if (k == 3 || k == 9) begin
        queue_cmd(FUNC_TICK, 0, 32'd0, 32'hFFFF_FFFF, 1'b1);
        for (int i = 0; i < 64; i++) order[i] = i;
        for (int i = 63; i > 0; i--) begin
          r        = $urandom_range(0, i);
          tmp      = order[i];
          order[i] = order[r];
          order[r] = tmp;
        end
        base = (k == 3) ? 32'd1000 : 32'hFFFF_FF00;
        for (int i = 0; i < 64; i++)
          queue_cmd(FUNC_ADD, order[i], base + $urandom_range(0, 40), 32'd0, 1'b0);
        queue_cmd(FUNC_ADD, $urandom_range(0, 63), base, 32'd0, 1'b0);
        queue_cmd(FUNC_ADJUST, $urandom_range(0, 63), base + $urandom_range(0, 40),
                  32'd0, 1'b0);
        if (k == 9) begin
          queue_cmd(FUNC_DELETE, order[0], 32'd0, 32'd0, 1'b0);
          queue_cmd(FUNC_ADD, order[0], base + 32'd20, 32'd0, 1'b0);
          queue_cmd(FUNC_TICK, 0, 32'd0, base + 32'd20, 1'b0);
        end
        queue_cmd(FUNC_TICK, 0, 32'd0, 32'hFFFF_FFFF, 1'b0);
      end else begin
        seq_len = $urandom_range(8, 20);
        pool_lo = $urandom_range(0, 48);
        case ($urandom_range(0, 7))
          0:       base = $urandom_range(0, 30);
          1:       base = 32'hFFFF_FFC0;
          default: base = $urandom;
        endcase
        for (int i = 0; i < seq_len; i++) begin
          r = $urandom_range(0, 99);
          if (r < 40)
            queue_cmd(FUNC_ADD, pool_lo + $urandom_range(0, 15),
                      base + $urandom_range(0, 60), $urandom, i == 0 && r < 10);
          else if (r < 55)
            queue_cmd(FUNC_ADJUST, pool_lo + $urandom_range(0, 15),
                      base + $urandom_range(0, 60), $urandom, 1'b0);
          else if (r < 65)
            queue_cmd(FUNC_DELETE, pool_lo + $urandom_range(0, 15), $urandom, $urandom,
                      1'b0);
          else if (r < 85)
            queue_cmd(FUNC_TICK, $urandom_range(0, 63), $urandom,
                      base + $urandom_range(0, 60), 1'b0);
          else
            queue_cmd(func_t'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom,
                      $urandom, 1'b0);
        end
      end
      k++;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() != 0 || have_cur || start) @(posedge clk);
    while (timer_reports.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("Run covered %0d commands and %0d result beats: %0d timers fired,",
             cmds_sent, beats_checked, timers_fired);
    $display("longest tick burst %0d, including full-list fills and time extremes.",
             max_burst);
    if (fails == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
